// File: hdl/aal_pkg.sv
package aal_pkg;

  // Coordinate width of the endpoint fields; pixel coordinates carry one more bit.
  localparam int COORD_BITS = 12;
  localparam int PIX_BITS   = COORD_BITS + 1;

  // Slope fraction and coverage accumulator width.
  localparam int SLOPE_BITS = 16;
  localparam int CNT_BITS   = $clog2(SLOPE_BITS + 1);

  localparam int COLOR_BITS = 32;
  localparam int ALPHA_BITS = 8;

  // Input item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/aal_slope_div.sv
// Radix-2 restoring divider: one quotient bit per cycle, shifted in at the bottom.
// Computes (minor_len << SLOPE_BITS) / major_len, keeping the low SLOPE_BITS bits.
module aal_slope_div import aal_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] major_len,
  input  logic [COORD_BITS-1:0] minor_len,
  output div_stat_t             stat,
  output logic [SLOPE_BITS-1:0] quot
);

  logic [COORD_BITS-1:0] rem_r, rem_nxt, div_r;
  logic [SLOPE_BITS-1:0] quo_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r, done_r;
  logic [COORD_BITS:0]   dbl, diff;
  logic                  ge;

  assign dbl     = {rem_r, 1'b0};
  assign diff    = dbl - {1'b0, div_r};
  assign ge      = dbl >= {1'b0, div_r};
  // remainder stays below the divisor, so both picks fit the narrow register
  assign rem_nxt = ge ? diff[COORD_BITS-1:0] : dbl[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(SLOPE_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // minor == major gives an integer part of one, dropped by truncation
      rem_r <= (minor_len == major_len) ? '0 : minor_len;
      div_r <= major_len;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[SLOPE_BITS-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule

// File: hdl/antialiased_line_stepper.sv
// Antialiased line stepper (Wu-style coverage stepping).
// Input channel in_*: valid/ready. in_kind selects a load (endpoints and colour
// latched, no result) or a step (at most one result). A step while no line is
// active is taken and gives nothing; a load during a run drops that run.
// Result channel out_*: valid/ready, one pixel pair per step; out_last marks
// the closing endpoint pixel, after which the block is idle again.
// A step's result is registered and shows on out_* in the cycle after its transfer.
// Throughput: one step per cycle while the receiver keeps out_ready high.
// A sloped load runs the bit-serial slope divider, during which in_ready is low;
// that divider sets the load cost.
// Horizontal, vertical and single-point loads skip the divider.
// The output register decouples the sides: a new input is taken while a
// result waits, as long as that result is taken in the same cycle.
// When out_ready stays low the held result stays put and in_ready drops.
// Reset (rst_n low, synchronous) leaves the block idle with no result pending.
module antialiased_line_stepper import aal_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [COLOR_BITS-1:0]        in_line_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PIX_BITS-1:0]   out_main_x,
  output logic signed [PIX_BITS-1:0]   out_main_y,
  output logic [COLOR_BITS-1:0]        out_main_color,
  output logic signed [PIX_BITS-1:0]   out_side_x,
  output logic signed [PIX_BITS-1:0]   out_side_y,
  output logic [COLOR_BITS-1:0]        out_side_color,
  output logic                         out_side_valid,
  output logic                         out_blended,
  output logic                         out_last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // line state
  logic signed [COORD_BITS-1:0] major_pos_r, major_end_r, far_x_r, far_y_r;
  logic signed [PIX_BITS-1:0]   minor_pos_r;
  logic [SLOPE_BITS-1:0]        acc_r, slope_r;
  logic [COLOR_BITS-1:0]        color_r;
  logic                         steep_r, down_r, axis_r;

  // result register
  logic signed [PIX_BITS-1:0] main_x_r, main_y_r, side_x_r, side_y_r;
  logic [COLOR_BITS-1:0]      main_color_r, side_color_r;
  logic                       side_valid_r, blended_r, last_r;

  logic take, do_load, do_step;

  // ---------------- load decode ----------------
  logic                         ld_axis, ld_swap, ld_vneg, ld_steep;
  logic signed [COORD_BITS-1:0] sx0, sy0, sx1, sy1;
  logic signed [PIX_BITS-1:0]   ld_vs, ld_vabs, ld_hd;
  logic [COORD_BITS-1:0]        ld_h, ld_v;
  logic signed [COORD_BITS-1:0] ld_major, ld_end, ld_far_x, ld_far_y;
  logic signed [COORD_BITS-1:0] ld_minor;
  logic                         ld_down, ld_steep_sel;

  div_stat_t             div_stat;
  logic [SLOPE_BITS-1:0] div_quot;

  assign ld_axis = (in_start_x == in_end_x) || (in_start_y == in_end_y);
  assign ld_swap = in_start_x > in_end_x;
  assign sx0     = ld_swap ? in_end_x   : in_start_x;
  assign sy0     = ld_swap ? in_end_y   : in_start_y;
  assign sx1     = ld_swap ? in_start_x : in_end_x;
  assign sy1     = ld_swap ? in_start_y : in_end_y;
  assign ld_hd   = PIX_BITS'(sx1) - PIX_BITS'(sx0);
  assign ld_vs   = PIX_BITS'(sy1) - PIX_BITS'(sy0);
  assign ld_vneg = ld_vs[PIX_BITS-1];
  assign ld_vabs = ld_vneg ? -ld_vs : ld_vs;
  assign ld_h    = ld_hd[COORD_BITS-1:0];
  assign ld_v    = ld_vabs[COORD_BITS-1:0];
  assign ld_steep = ld_h < ld_v;

  always_comb begin
    if (ld_axis) begin
      // no swap; run from start to end inclusive
      ld_far_x = in_end_x;
      ld_far_y = in_end_y;
      if (in_start_y == in_end_y) begin
        ld_steep_sel = 1'b0;
        ld_major     = in_start_x;
        ld_end       = in_end_x;
        ld_minor     = in_start_y;
        ld_down      = in_end_x < in_start_x;
      end else begin
        ld_steep_sel = 1'b1;
        ld_major     = in_start_y;
        ld_end       = in_end_y;
        ld_minor     = in_start_x;
        ld_down      = in_end_y < in_start_y;
      end
    end else begin
      ld_far_x     = sx1;
      ld_far_y     = sy1;
      ld_steep_sel = ld_steep;
      ld_down      = ld_vneg;
      if (ld_steep) begin
        ld_major = sy0;
        ld_end   = sy1;
        ld_minor = sx0;
      end else begin
        ld_major = sx0;
        ld_end   = sx1;
        ld_minor = sy0;
      end
    end
  end

  aal_slope_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (do_load && !ld_axis),
    .major_len (ld_steep ? ld_v : ld_h),
    .minor_len (ld_steep ? ld_h : ld_v),
    .stat      (div_stat),
    .quot      (div_quot)
  );

  // ---------------- handshake ----------------
  assign in_ready = (state_r != S_DIV) && (!out_valid_r || out_ready);
  assign take     = in_valid && in_ready;
  assign do_load  = take && (in_kind == KIND_LOAD);
  assign do_step  = take && (in_kind == KIND_STEP) && (state_r == S_RUN);

  // ---------------- step datapath ----------------
  logic                       at_end, acc_wrap;
  logic signed [PIX_BITS-1:0] px, py, major_ext, dir_pix;
  logic [SLOPE_BITS-1:0]      acc_sum;

  assign at_end    = major_pos_r == major_end_r;
  assign major_ext = PIX_BITS'(major_pos_r);
  assign px        = steep_r ? minor_pos_r : major_ext;
  assign py        = steep_r ? major_ext : minor_pos_r;
  assign dir_pix   = down_r ? -PIX_BITS'(1) : PIX_BITS'(1);
  assign acc_sum   = acc_r + slope_r;
  assign acc_wrap  = acc_sum <= acc_r;

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (do_load) state_nxt = ld_axis ? S_RUN : S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (do_load)               state_nxt = ld_axis ? S_RUN : S_DIV;
        else if (do_step && at_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (do_step)        out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    if (do_load) begin
      major_pos_r <= ld_major;
      major_end_r <= ld_end;
      minor_pos_r <= PIX_BITS'(ld_minor);
      far_x_r     <= ld_far_x;
      far_y_r     <= ld_far_y;
      acc_r       <= '0;
      slope_r     <= '0;
      color_r     <= in_line_color;
      steep_r     <= ld_steep_sel;
      down_r      <= ld_down;
      axis_r      <= ld_axis;
    end else if (div_stat.done) begin
      slope_r <= div_quot;
    end else if (do_step) begin
      if (at_end) begin
        // closing endpoint, opaque
        main_x_r     <= PIX_BITS'(far_x_r);
        main_y_r     <= PIX_BITS'(far_y_r);
        main_color_r <= color_r;
        side_x_r     <= '0;
        side_y_r     <= '0;
        side_color_r <= '0;
        side_valid_r <= 1'b0;
        blended_r    <= 1'b0;
        last_r       <= 1'b1;
      end else if (axis_r) begin
        main_x_r     <= px;
        main_y_r     <= py;
        main_color_r <= color_r;
        side_x_r     <= '0;
        side_y_r     <= '0;
        side_color_r <= '0;
        side_valid_r <= 1'b0;
        blended_r    <= 1'b0;
        last_r       <= 1'b0;
        major_pos_r  <= down_r ? major_pos_r - COORD_BITS'(1)
                               : major_pos_r + COORD_BITS'(1);
      end else begin
        main_x_r     <= px;
        main_y_r     <= py;
        main_color_r <= {color_r[COLOR_BITS-1:ALPHA_BITS],
                         ~acc_r[SLOPE_BITS-1 -: ALPHA_BITS]};
        side_x_r     <= steep_r ? px + PIX_BITS'(1) : px;
        side_y_r     <= steep_r ? py : py + dir_pix;
        side_color_r <= {color_r[COLOR_BITS-1:ALPHA_BITS],
                         acc_r[SLOPE_BITS-1 -: ALPHA_BITS]};
        side_valid_r <= 1'b1;
        blended_r    <= 1'b1;
        last_r       <= 1'b0;
        acc_r        <= acc_sum;
        // minor axis moves when coverage wraps
        if (acc_wrap) minor_pos_r <= minor_pos_r + (steep_r ? PIX_BITS'(1) : dir_pix);
        if (steep_r && down_r) major_pos_r <= major_pos_r - COORD_BITS'(1);
        else                   major_pos_r <= major_pos_r + COORD_BITS'(1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_main_x     = main_x_r;
  assign out_main_y     = main_y_r;
  assign out_main_color = main_color_r;
  assign out_side_x     = side_x_r;
  assign out_side_y     = side_y_r;
  assign out_side_color = side_color_r;
  assign out_side_valid = side_valid_r;
  assign out_blended    = blended_r;
  assign out_last       = last_r;

  // ---------------- checks ----------------
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> state_r == S_DIV)
    else $error("divider active outside the divide state");

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    do_step |=> out_valid)
    else $error("accepted step produced no result");

  a_side_matches_blend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_side_valid == out_blended))
    else $error("neighbour valid disagrees with blend flag");

  a_last_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !out_blended)
    else $error("closing pixel is blended");

  a_run_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (do_step && at_end && !do_load) |=> state_r == S_IDLE)
    else $error("run did not end after closing pixel");

endmodule
